FILE: rtl/core/sum8_checked_frame_deframer_core_defines.svh
// Assertion macros for the sum8 checked frame deframer.
`ifndef SUM8_CHECKED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SUM8_CHECKED_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTH
`define SFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define SFD_ASSERT_SAME(lbl, ante, cons)
`define SFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/sfd_pkg.sv
package sfd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HEADER   = 3'd1,
    PH_FUNC     = 3'd2,
    PH_LEN_LO   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_CHECKSUM = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_FUNC_MARK = 3'd1,
    ERR_BAD_LEN   = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_CHECKSUM  = 3'd4,
    ERR_SIZE      = 3'd5
  } err_t;

  localparam logic [1:0] CFG_HEADER_BYTE   = 2'd0;
  localparam logic [1:0] CFG_FRAME_MARK    = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd2;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd5;
  // Header, function mark and the two length bytes precede the payload.
  localparam logic [15:0] PAYLOAD_OFS   = 16'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       is_header;
    logic       is_fmark;
  } byte_cls_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        in_payload;
    logic [15:0] payload_index;
    logic        frame_end;
    logic        frame_good;
    err_t        error_code;
    logic [15:0] frame_len_seen;
    logic [31:0] good_frames;
    logic [31:0] error_total;
    logic [31:0] overrun_total;
    phase_t      hunt_phase;
  } result_t;

endpackage

FILE: rtl/core/sum8_checked_frame_deframer_core.sv
// Channel  | Direction | Handshake          | Word
// ---------+-----------+--------------------+-------------------------------------
// in_      | input     | in_valid/in_stall  | in_rx_byte
// out_     | output    | out_valid/out_stall| status of one byte, eleven fields
// cfg_     | input     | cfg_we             | cfg_index selects, cfg_wdata value
//
// One word is accepted per cycle while in_stall is low; one status word leaves per accepted word.
// A word passes the classifier and a two-entry queue, then the parser updates
// its state and loads the output register.
// Reset is synchronous on rst_n; the block takes words as soon as it is released.
// A stalled output holds its word; the queue fills, then in_stall rises.
module sum8_checked_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_in_payload,
  output logic [15:0] out_payload_index,
  output logic        out_frame_end,
  output logic        out_frame_good,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_frame_len_seen,
  output logic [31:0] out_good_frames,
  output logic [31:0] out_error_total,
  output logic [31:0] out_overrun_total,
  output logic [2:0]  out_hunt_phase,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sfd_pkg::*;

`include "sum8_checked_frame_deframer_core_defines.svh"

  logic [7:0]  header_byte_r;
  logic [7:0]  frame_mark_r;
  logic [15:0] max_frame_len_r;
  logic        q_valid;
  logic        q_pop;
  byte_cls_t   q_item;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r   <= 8'd85;
      frame_mark_r    <= 8'd4;
      max_frame_len_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_BYTE:   header_byte_r   <= cfg_wdata[7:0];
        CFG_FRAME_MARK:    frame_mark_r    <= cfg_wdata[7:0];
        CFG_MAX_FRAME_LEN: max_frame_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .header_byte   (header_byte_r),
    .frame_mark    (frame_mark_r),
    .q_pop         (q_pop),
    .q_valid       (q_valid),
    .q_item        (q_item)
  );

  sfd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .max_frame_len (max_frame_len_r),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_res       (res)
  );

  assign out_data_byte      = res.data_byte;
  assign out_in_payload     = res.in_payload;
  assign out_payload_index  = res.payload_index;
  assign out_frame_end      = res.frame_end;
  assign out_frame_good     = res.frame_good;
  assign out_error_code     = res.error_code;
  assign out_frame_len_seen = res.frame_len_seen;
  assign out_good_frames    = res.good_frames;
  assign out_error_total    = res.error_total;
  assign out_overrun_total  = res.overrun_total;
  assign out_hunt_phase     = res.hunt_phase;

  `SFD_ASSERT_SAME(a_good_is_clean_end, out_valid && out_frame_good, out_frame_end && out_error_code == ERR_NONE)
  `SFD_ASSERT_SAME(a_error_ends_frame, out_valid && out_error_code != ERR_NONE, out_frame_end && !out_frame_good)
  `SFD_ASSERT_SAME(a_end_returns_idle, out_valid && out_frame_end, out_hunt_phase == PH_IDLE)
  `SFD_ASSERT_NEXT(a_stalled_word_kept, out_valid && out_stall, out_valid && $stable(res))

endmodule

FILE: rtl/core/sfd_front.sv
module sfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic [7:0]        header_byte,
  input  logic [7:0]        frame_mark,
  input  logic              q_pop,
  output logic              q_valid,
  output sfd_pkg::byte_cls_t q_item
);
  import sfd_pkg::*;

  byte_cls_t   q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  byte_cls_t   cls;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  // The compares against configuration are done here so the parser only sees flags.
  always_comb begin
    cls.data      = in_rx_byte;
    cls.is_header = (in_rx_byte == header_byte);
    cls.is_fmark  = (in_rx_byte == frame_mark);
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: rtl/core/sfd_back.sv
module sfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sfd_pkg::byte_cls_t q_item,
  output logic               q_pop,
  input  logic [15:0]        max_frame_len,
  input  logic               out_stall,
  output logic               out_valid,
  output sfd_pkg::result_t   out_res
);
  import sfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] total_len_r, total_len_nxt;
  logic [15:0] byte_pos_r, byte_pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] err_r, err_nxt;
  logic [31:0] ovr_r, ovr_nxt;
  logic        out_valid_r;
  result_t     res_r, res_nxt;

  logic [7:0]  b;
  logic [15:0] len_full;
  logic [15:0] pos_inc;
  logic        in_pay;
  logic [15:0] pidx;
  logic        fend;
  logic        fgood;
  err_t        ecode;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign q_pop     = q_valid && (!out_valid_r || !out_stall);

  assign b        = q_item.data;
  assign len_full = {b, total_len_r[7:0]};
  assign pos_inc  = byte_pos_r + 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    total_len_nxt = total_len_r;
    byte_pos_nxt  = byte_pos_r;
    sum_nxt       = sum_r;
    good_nxt      = good_r;
    err_nxt       = err_r;
    ovr_nxt       = ovr_r;
    in_pay        = 1'b0;
    pidx          = 16'd0;
    fend          = 1'b0;
    fgood         = 1'b0;
    ecode         = ERR_NONE;
    unique case (phase_r)
      PH_HEADER: begin
        if (q_item.is_fmark) begin
          phase_nxt    = PH_FUNC;
          byte_pos_nxt = pos_inc;
          sum_nxt      = sum_r + b;
        end else begin
          phase_nxt = PH_IDLE;
          err_nxt   = err_r + 32'd1;
          ecode     = ERR_FUNC_MARK;
          fend      = 1'b1;
        end
      end
      PH_FUNC: begin
        total_len_nxt = {8'd0, b};
        byte_pos_nxt  = pos_inc;
        sum_nxt       = sum_r + b;
        phase_nxt     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        total_len_nxt = len_full;
        byte_pos_nxt  = pos_inc;
        sum_nxt       = sum_r + b;
        if (len_full < MIN_FRAME_LEN || len_full > max_frame_len) begin
          phase_nxt = PH_IDLE;
          err_nxt   = err_r + 32'd1;
          ovr_nxt   = ovr_r + 32'd1;
          ecode     = ERR_BAD_LEN;
          fend      = 1'b1;
        end else if (len_full == MIN_FRAME_LEN) begin
          phase_nxt = PH_CHECKSUM;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        in_pay       = 1'b1;
        pidx         = byte_pos_r - PAYLOAD_OFS;
        byte_pos_nxt = pos_inc;
        sum_nxt      = sum_r + b;
        if ((pos_inc - PAYLOAD_OFS) >= (total_len_r - MIN_FRAME_LEN)) begin
          phase_nxt = PH_CHECKSUM;
        end
        // Only reachable if the length limit was lowered in the middle of a frame.
        if (pos_inc >= max_frame_len) begin
          phase_nxt = PH_IDLE;
          err_nxt   = err_r + 32'd1;
          ovr_nxt   = ovr_r + 32'd1;
          ecode     = ERR_OVERFLOW;
          fend      = 1'b1;
        end
      end
      PH_CHECKSUM: begin
        byte_pos_nxt = pos_inc;
        fend         = 1'b1;
        phase_nxt    = PH_IDLE;
        if (b == sum_r) begin
          if (pos_inc == total_len_r) begin
            good_nxt = good_r + 32'd1;
            fgood    = 1'b1;
          end else begin
            err_nxt = err_r + 32'd1;
            ecode   = ERR_SIZE;
          end
        end else begin
          err_nxt = err_r + 32'd1;
          ecode   = ERR_CHECKSUM;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (q_item.is_header) begin
          sum_nxt      = b;
          byte_pos_nxt = 16'd1;
          phase_nxt    = PH_HEADER;
        end
      end
    endcase

    res_nxt.data_byte      = b;
    res_nxt.in_payload     = in_pay;
    res_nxt.payload_index  = pidx;
    res_nxt.frame_end      = fend;
    res_nxt.frame_good     = fgood;
    res_nxt.error_code     = ecode;
    res_nxt.frame_len_seen = total_len_nxt;
    res_nxt.good_frames    = good_nxt;
    res_nxt.error_total    = err_nxt;
    res_nxt.overrun_total  = ovr_nxt;
    res_nxt.hunt_phase     = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      total_len_r <= 16'd0;
      byte_pos_r  <= 16'd0;
      sum_r       <= 8'd0;
      good_r      <= 32'd0;
      err_r       <= 32'd0;
      ovr_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        total_len_r <= total_len_nxt;
        byte_pos_r  <= byte_pos_nxt;
        sum_r       <= sum_nxt;
        good_r      <= good_nxt;
        err_r       <= err_nxt;
        ovr_r       <= ovr_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import sfd_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int GAP_PERCENT = 38;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_in_payload;
  logic [15:0] out_payload_index;
  logic        out_frame_end;
  logic        out_frame_good;
  logic [2:0]  out_error_code;
  logic [15:0] out_frame_len_seen;
  logic [31:0] out_good_frames;
  logic [31:0] out_error_total;
  logic [31:0] out_overrun_total;
  logic [2:0]  out_hunt_phase;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'h0000;

  sum8_checked_frame_deframer_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data_byte(out_data_byte),
    .out_in_payload(out_in_payload),
    .out_payload_index(out_payload_index),
    .out_frame_end(out_frame_end),
    .out_frame_good(out_frame_good),
    .out_error_code(out_error_code),
    .out_frame_len_seen(out_frame_len_seen),
    .out_good_frames(out_good_frames),
    .out_error_total(out_error_total),
    .out_overrun_total(out_overrun_total),
    .out_hunt_phase(out_hunt_phase),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser copy: register settings and frame tracking state.
  logic [7:0]  hdr_cfg = 8'd85;
  logic [7:0]  fmark_cfg = 8'd4;
  logic [15:0] maxlen_cfg = 16'd256;
  phase_t      ph = PH_IDLE;
  logic [15:0] tot_len = 16'd0;
  logic [15:0] pos = 16'd0;
  logic [7:0]  sum8 = 8'd0;
  logic [31:0] good_cnt = 32'd0;
  logic [31:0] err_cnt = 32'd0;
  logic [31:0] ovr_cnt = 32'd0;

  logic [7:0] byte_queue[$];
  result_t    expected_status[$];
  result_t    want;
  int         queued_bytes = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         steady = 1'b0;

  function automatic result_t deframe_byte(logic [7:0] b);
    result_t r;
    r = '0;
    r.data_byte = b;
    r.error_code = ERR_NONE;
    case (ph)
      PH_HEADER: begin
        if (b == fmark_cfg) begin
          ph = PH_FUNC;
          pos = pos + 16'd1;
          sum8 = sum8 + b;
        end else begin
          ph = PH_IDLE;
          err_cnt = err_cnt + 32'd1;
          r.error_code = ERR_FUNC_MARK;
          r.frame_end = 1'b1;
        end
      end
      PH_FUNC: begin
        tot_len = {8'h00, b};
        pos = pos + 16'd1;
        sum8 = sum8 + b;
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        tot_len = {b, tot_len[7:0]};
        pos = pos + 16'd1;
        sum8 = sum8 + b;
        if (tot_len < MIN_FRAME_LEN || tot_len > maxlen_cfg) begin
          ph = PH_IDLE;
          err_cnt = err_cnt + 32'd1;
          ovr_cnt = ovr_cnt + 32'd1;
          r.error_code = ERR_BAD_LEN;
          r.frame_end = 1'b1;
        end else if (tot_len == MIN_FRAME_LEN) begin
          ph = PH_CHECKSUM;
        end else begin
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.in_payload = 1'b1;
        r.payload_index = pos - PAYLOAD_OFS;
        pos = pos + 16'd1;
        sum8 = sum8 + b;
        if (16'(pos - PAYLOAD_OFS) >= 16'(tot_len - MIN_FRAME_LEN)) ph = PH_CHECKSUM;
        // A limit lowered mid-frame cuts the frame off on this byte.
        if (pos >= maxlen_cfg) begin
          ph = PH_IDLE;
          err_cnt = err_cnt + 32'd1;
          ovr_cnt = ovr_cnt + 32'd1;
          r.error_code = ERR_OVERFLOW;
          r.frame_end = 1'b1;
        end
      end
      PH_CHECKSUM: begin
        pos = pos + 16'd1;
        r.frame_end = 1'b1;
        ph = PH_IDLE;
        if (b == sum8) begin
          if (pos == tot_len) begin
            good_cnt = good_cnt + 32'd1;
            r.frame_good = 1'b1;
          end else begin
            err_cnt = err_cnt + 32'd1;
            r.error_code = ERR_SIZE;
          end
        end else begin
          err_cnt = err_cnt + 32'd1;
          r.error_code = ERR_CHECKSUM;
        end
      end
      default: begin
        ph = PH_IDLE;
        if (b == hdr_cfg) begin
          sum8 = b;
          pos = 16'd1;
          ph = PH_HEADER;
        end
      end
    endcase
    r.frame_len_seen = tot_len;
    r.good_frames = good_cnt;
    r.error_total = err_cnt;
    r.overrun_total = ovr_cnt;
    r.hunt_phase = ph;
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  function automatic void compare_status(result_t w);
    check_field("data_byte", w.data_byte, out_data_byte);
    check_field("in_payload", w.in_payload, out_in_payload);
    check_field("payload_index", w.payload_index, out_payload_index);
    check_field("frame_end", w.frame_end, out_frame_end);
    check_field("frame_good", w.frame_good, out_frame_good);
    check_field("error_code", w.error_code, out_error_code);
    check_field("frame_len_seen", w.frame_len_seen, out_frame_len_seen);
    check_field("good_frames", w.good_frames, out_good_frames);
    check_field("error_total", w.error_total, out_error_total);
    check_field("overrun_total", w.overrun_total, out_overrun_total);
    check_field("hunt_phase", w.hunt_phase, out_hunt_phase);
  endfunction

  // Byte source: a word leaves the queue only when the previous one was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_status.push_back(deframe_byte(in_rx_byte));
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() > 0 && (steady || $urandom_range(0, 99) >= GAP_PERCENT)) begin
          in_valid <= 1'b1;
          in_rx_byte <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t: status word with none expected, data_byte %0h", $time, out_data_byte);
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          compare_status(want);
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < GAP_PERCENT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEADER_BYTE:   hdr_cfg = val[7:0];
      CFG_FRAME_MARK:    fmark_cfg = val[7:0];
      CFG_MAX_FRAME_LEN: maxlen_cfg = val;
      default: ;
    endcase
  endtask

  task automatic push_byte(logic [7:0] b);
    byte_queue.push_back(b);
    queued_bytes++;
  endtask

  task automatic push_head(logic [15:0] flen);
    push_byte(hdr_cfg);
    push_byte(fmark_cfg);
    push_byte(flen[7:0]);
    push_byte(flen[15:8]);
  endtask

  task automatic push_frame(int plen, bit bad_sum);
    logic [15:0] flen;
    logic [7:0]  csum;
    logic [7:0]  b;
    flen = 16'(plen + 5);
    push_head(flen);
    csum = hdr_cfg + fmark_cfg;
    csum = csum + flen[7:0];
    csum = csum + flen[15:8];
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom_range(0, 255));
      csum = csum + b;
      push_byte(b);
    end
    if (bad_sum) csum = csum + 8'($urandom_range(1, 255));
    push_byte(csum);
  endtask

  task automatic push_payload(int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed frames; the rest are corrupted frames and line noise.
  task automatic gen_traffic(int n);
    int target;
    int pick;
    int plen;
    logic [7:0] b;
    target = queued_bytes + n;
    while (queued_bytes < target) begin
      pick = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (pick < 70) begin
        push_frame(plen, 1'b0);
      end else if (pick < 78) begin
        push_frame(plen, 1'b1);
      end else if (pick < 84) begin
        b = 8'($urandom_range(0, 255));
        if (b == fmark_cfg) b = b ^ 8'h01;
        push_byte(hdr_cfg);
        push_byte(b);
      end else if (pick < 90) begin
        if (maxlen_cfg < 16'hFFFF && $urandom_range(0, 1) == 1)
          push_head(16'($urandom_range(maxlen_cfg + 1, 65535)));
        else
          push_head(16'($urandom_range(0, 4)));
      end else begin
        push_payload($urandom_range(1, 3));
      end
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks at the reset settings.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(0, 1'b0);
    push_byte(hdr_cfg);
    push_byte(fmark_cfg ^ 8'h01);
    push_head(16'd4);
    push_head(16'd257);
    push_frame(1, 1'b1);
    wait_drained();

    // The unused register index must leave the settings alone.
    write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));

    // Lower the limit in the middle of a frame to force an overflow.
    push_head(16'd12);
    push_payload(3);
    wait_drained();
    write_reg(CFG_MAX_FRAME_LEN, 16'd6);
    push_payload(2);
    wait_drained();

    write_reg(CFG_HEADER_BYTE, 16'h0000);
    write_reg(CFG_FRAME_MARK, 16'h00FF);
    write_reg(CFG_MAX_FRAME_LEN, 16'd5);
    push_frame(0, 1'b0);
    push_frame(1, 1'b0);
    push_frame(0, 1'b1);
    wait_drained();

    write_reg(CFG_HEADER_BYTE, 16'h00FF);
    write_reg(CFG_FRAME_MARK, 16'h0000);
    write_reg(CFG_MAX_FRAME_LEN, 16'hFFFF);
    push_frame(3, 1'b0);
    push_head(16'hFFFF);
    push_payload(3);
    wait_drained();
    write_reg(CFG_MAX_FRAME_LEN, 16'd5);
    push_payload(1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      steady = (p == 2);
      write_reg(CFG_HEADER_BYTE, 16'($urandom_range(0, 255)));
      write_reg(CFG_FRAME_MARK, 16'($urandom_range(0, 255)));
      write_reg(CFG_MAX_FRAME_LEN,
                ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(5, 48)));
      gen_traffic(100);
      wait_drained();
    end
    steady = 1'b0;

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
